// File: rtl/core/ils_pkg.sv
// Shared types, constants and helpers for the indexed list store.
package ils_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Width of a slot index and of the entry count, which must hold CAPACITY itself.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Width used to compare the 8-bit position against the count.
  localparam int CMP_W = CNT_W + 8;

  localparam int REQ_W   = 3;
  localparam int POS_W   = 8;
  localparam int PORT_DW = 32;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND_END   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_AT    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE_FIRST = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_AT      = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_WRITE,
    CELL_CLOSE
  } cell_op_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] slot;
    word_t            word;
    logic             ret;
  } ils_ctl_t;

  function automatic word_t to_word(input logic [PORT_DW-1:0] x);
    word_t w;
    w = '0;
    for (int i = 0; i < DATA_WIDTH && i < PORT_DW; i++) w[i] = x[i];
    return w;
  endfunction

  function automatic logic [PORT_DW-1:0] from_word(input word_t w);
    logic [PORT_DW-1:0] x;
    x = '0;
    for (int i = 0; i < DATA_WIDTH && i < PORT_DW; i++) x[i] = w[i];
    return x;
  endfunction

  function automatic logic [ECNT_W-1:0] to_ecnt(input logic [CNT_W-1:0] c);
    logic [ECNT_W-1:0] e;
    e = '0;
    for (int i = 0; i < ECNT_W && i < CNT_W; i++) e[i] = c[i];
    return e;
  endfunction

endpackage

// File: rtl/core/ils_if.sv
// Request and response channel interfaces of the indexed list store.
interface ils_req_if;
  logic                          valid;
  logic                          ready;
  logic [ils_pkg::REQ_W-1:0]     req_type;
  logic [ils_pkg::POS_W-1:0]     position;
  logic [ils_pkg::PORT_DW-1:0]   data_in;

  modport source (output valid, req_type, position, data_in, input ready);
  modport sink   (input valid, req_type, position, data_in, output ready);
endinterface

interface ils_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ils_pkg::PORT_DW-1:0]   data_out;
  logic [ils_pkg::STAT_W-1:0]    status;
  logic [ils_pkg::ECNT_W-1:0]    entry_count;

  modport source (output valid, data_out, status, entry_count, input ready);
  modport sink   (input valid, data_out, status, entry_count, output ready);
endinterface

// File: rtl/core/ils_cell.sv
// One storage cell of the list chain; shifts with its neighbors on insert and remove.
module ils_cell (
  input  logic                      clk,
  input  logic [ils_pkg::IDX_W-1:0] idx,
  input  ils_pkg::ils_ctl_t         ctl,
  input  ils_pkg::word_t            prev_d,
  input  ils_pkg::word_t            next_d,
  output ils_pkg::word_t            data_q
);

  ils_pkg::word_t data_r;
  ils_pkg::word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      ils_pkg::CELL_PUSH_FRONT: data_nxt = (idx == '0) ? ctl.word : prev_d;
      ils_pkg::CELL_WRITE: begin
        if (idx == ctl.slot) data_nxt = ctl.word;
      end
      ils_pkg::CELL_CLOSE: begin
        if (idx >= ctl.slot) data_nxt = next_d;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Payload only; contents are meaningless until written.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// File: rtl/core/ils_ctrl.sv
// Request decoder and entry counter that steers the cell chain.
module ils_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ils_pkg::REQ_W-1:0]   req_type,
  input  logic [ils_pkg::POS_W-1:0]   position,
  input  logic [ils_pkg::PORT_DW-1:0] data_in,
  output ils_pkg::ils_ctl_t           ctl,
  output logic [ils_pkg::STAT_W-1:0]  status,
  output logic [ils_pkg::CNT_W-1:0]   count_nxt
);

  localparam logic [ils_pkg::CNT_W-1:0] CAP = ils_pkg::CNT_W'(ils_pkg::CAPACITY);

  logic [ils_pkg::CNT_W-1:0] count_r;
  logic                      full;
  logic                      empty;
  logic                      pos_bad;

  assign full    = (count_r == CAP);
  assign empty   = (count_r == '0);
  assign pos_bad = (ils_pkg::CMP_W'(position) >= ils_pkg::CMP_W'(count_r));

  always_comb begin
    ctl.op    = ils_pkg::CELL_HOLD;
    ctl.slot  = '0;
    ctl.word  = ils_pkg::to_word(data_in);
    ctl.ret   = 1'b0;
    status    = ils_pkg::ST_OK;
    count_nxt = count_r;
    unique case (req_type)
      ils_pkg::REQ_INSERT_FRONT: begin
        if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctl.op    = ils_pkg::CELL_PUSH_FRONT;
          count_nxt = count_r + 1'b1;
        end
      end
      ils_pkg::REQ_APPEND_END: begin
        if (full) begin
          status = ils_pkg::ST_FULL;
        end else begin
          ctl.op    = ils_pkg::CELL_WRITE;
          ctl.slot  = count_r[ils_pkg::IDX_W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      ils_pkg::REQ_REMOVE_AT: begin
        if (pos_bad) begin
          status = ils_pkg::ST_RANGE;
        end else begin
          ctl.op    = ils_pkg::CELL_CLOSE;
          ctl.slot  = position[ils_pkg::IDX_W-1:0];
          ctl.ret   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      ils_pkg::REQ_REMOVE_FIRST: begin
        if (empty) begin
          status = ils_pkg::ST_EMPTY;
        end else begin
          ctl.op    = ils_pkg::CELL_CLOSE;
          ctl.ret   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      ils_pkg::REQ_READ_AT: begin
        if (pos_bad) begin
          status = ils_pkg::ST_RANGE;
        end else begin
          ctl.slot = position[ils_pkg::IDX_W-1:0];
          ctl.ret  = 1'b1;
        end
      end
      default: begin
        // Unused request codes leave the list alone and report success.
      end
    endcase
    if (!accept) ctl.op = ils_pkg::CELL_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("entry count above capacity");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status == ils_pkg::ST_FULL |=> $stable(count_r))
    else $error("full insert changed the count");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl.op == ils_pkg::CELL_CLOSE |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not decrement the count");

  a_cells_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ctl.op == ils_pkg::CELL_HOLD)
    else $error("cells moved without a request transfer");
`endif

endmodule

// File: rtl/core/indexed_list_store.sv
// Top level of the indexed list store: a chain of shifting cells with a result register.
//
// The block holds an ordered list of up to CAPACITY words, entry 0 at the front.
// Requests arrive on the in_req channel (req_type, position, data_in) and each
// transfer yields exactly one response on the out_rsp channel: the word removed
// or read (zero otherwise), a status code and the entry count after the request.
// Insert at front shifts every cell of the chain by one place and remove shifts
// the cells from the removed position on by one place, all in the same cycle.
// The response is valid in the cycle after the request transfer.
// Throughput: one request per cycle while responses are taken, set by the single
// result register; a new request is taken in the same cycle that the pending
// response is transferred. When the receiver stalls, the pending response is
// held and in_req.ready drops until it is taken; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// response. Stored words are not cleared; only entries below the count are
// ever read, so their contents before the first write do not matter.
// Status codes: ok, index out of range, list empty, list full. A full insert
// leaves the list unchanged.
module indexed_list_store (
  input  logic        clk,
  input  logic        rst_n,
  ils_req_if.sink     in_req,
  ils_rsp_if.source   out_rsp
);

  ils_pkg::ils_ctl_t                 ctl;
  logic [ils_pkg::STAT_W-1:0]        status;
  logic [ils_pkg::CNT_W-1:0]         count_nxt;
  logic                              accept;
  ils_pkg::word_t                    cell_q [ils_pkg::CAPACITY];

  logic                              out_valid_r;
  logic [ils_pkg::PORT_DW-1:0]       data_r;
  logic [ils_pkg::STAT_W-1:0]        status_r;
  logic [ils_pkg::ECNT_W-1:0]        ecnt_r;

  // A request may transfer whenever the result register is free or being emptied.
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req.req_type),
    .position  (in_req.position),
    .data_in   (in_req.data_in),
    .ctl       (ctl),
    .status    (status),
    .count_nxt (count_nxt)
  );

  // The chain: each cell sees its front neighbor for inserts and its back
  // neighbor for removes. The last cell keeps its own word on a remove.
  for (genvar g = 0; g < ils_pkg::CAPACITY; g++) begin : g_cell
    ils_pkg::word_t prev_d;
    ils_pkg::word_t next_d;

    if (g == 0) begin : g_front
      assign prev_d = '0;
    end else begin : g_mid_prev
      assign prev_d = cell_q[g-1];
    end

    if (g == ils_pkg::CAPACITY - 1) begin : g_back
      assign next_d = cell_q[g];
    end else begin : g_mid_next
      assign next_d = cell_q[g+1];
    end

    ils_cell u_cell (
      .clk    (clk),
      .idx    (ils_pkg::IDX_W'(g)),
      .ctl    (ctl),
      .prev_d (prev_d),
      .next_d (next_d),
      .data_q (cell_q[g])
    );
  end

  // Result register. The returned word is read from the chain before the
  // cells update, which is what a remove must report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r   <= ctl.ret ? ils_pkg::from_word(cell_q[ctl.slot]) : '0;
      status_r <= status;
      ecnt_r   <= ils_pkg::to_ecnt(count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.data_out    = data_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.entry_count = ecnt_r;

`ifndef ASSERT_OFF
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rsp.ready |=> out_valid_r && $stable(data_r) && $stable(status_r))
    else $error("pending response changed while stalled");

  a_no_ret_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status != ils_pkg::ST_OK |=> data_r == '0)
    else $error("failed request returned a word");

  a_accept_frees: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("request transfer without a response");
`endif

endmodule

// File: tb/tb_indexed_list_store.sv
// Self-checking testbench for the indexed list store: random and directed requests.
`timescale 1ns / 100ps

module tb_indexed_list_store;

  // Clock period and run limits, in ns, cycles or requests.
  localparam int      CLK_PERIOD   = 10;
  localparam int      RANDOM_ITEMS = 700;
  localparam int      LONG_HOLD    = 200;
  localparam int      DRAIN_LIMIT  = 4000;
  localparam longint  RUN_LIMIT_NS = 64'd5_000_000;

  // Ordered list model plus the queue of responses still owed by the block.
  // note_request() is called for every request transfer and check_response()
  // for every response transfer.
  class list_scoreboard;
    typedef struct packed {
      logic [ils_pkg::PORT_DW-1:0] data_out;
      logic [ils_pkg::STAT_W-1:0]  status;
      logic [ils_pkg::ECNT_W-1:0]  entry_count;
    } response_t;

    ils_pkg::word_t cells[$];
    response_t      owed[$];
    int             failures;

    function void note_request(input logic [ils_pkg::REQ_W-1:0] kind,
                               input logic [ils_pkg::POS_W-1:0] pos,
                               input logic [ils_pkg::PORT_DW-1:0] word);
      response_t r;
      r.data_out = '0;
      r.status   = ils_pkg::ST_OK;
      case (kind) inside
        ils_pkg::REQ_INSERT_FRONT, ils_pkg::REQ_APPEND_END: begin
          if (cells.size() >= ils_pkg::CAPACITY) begin
            r.status = ils_pkg::ST_FULL;
          end else if (kind == ils_pkg::REQ_INSERT_FRONT) begin
            cells.push_front(ils_pkg::word_t'(word));
          end else begin
            cells.push_back(ils_pkg::word_t'(word));
          end
        end
        ils_pkg::REQ_REMOVE_AT: begin
          if (int'(pos) >= cells.size()) begin
            r.status = ils_pkg::ST_RANGE;
          end else begin
            r.data_out = ils_pkg::PORT_DW'(cells[pos]);
            cells.delete(int'(pos));
          end
        end
        ils_pkg::REQ_REMOVE_FIRST: begin
          if (cells.size() == 0) begin
            r.status = ils_pkg::ST_EMPTY;
          end else begin
            r.data_out = ils_pkg::PORT_DW'(cells.pop_front());
          end
        end
        ils_pkg::REQ_READ_AT: begin
          if (int'(pos) >= cells.size()) begin
            r.status = ils_pkg::ST_RANGE;
          end else begin
            r.data_out = ils_pkg::PORT_DW'(cells[pos]);
          end
        end
        default: begin
          // Unused request codes leave the list alone and report ok.
        end
      endcase
      r.entry_count = ils_pkg::ECNT_W'(cells.size());
      owed.push_back(r);
    endfunction

    function void check_response(input logic [ils_pkg::PORT_DW-1:0] data_out,
                                 input logic [ils_pkg::STAT_W-1:0] status,
                                 input logic [ils_pkg::ECNT_W-1:0] entry_count);
      response_t r;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] unexpected response: data_out=%h status=%0d entry_count=%0d",
                   $time, data_out, status, entry_count);
        return;
      end
      r = owed.pop_front();
      if (r.data_out !== data_out || r.status !== status || r.entry_count !== entry_count) begin
        failures++;
        if (failures <= 10)
          $display({"[%0t] mismatch: data_out exp %h got %h, status exp %0d got %0d, ",
                    "count exp %0d got %0d"},
                   $time, r.data_out, data_out, r.status, status, r.entry_count, entry_count);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function int entries_held();
      return cells.size();
    endfunction
  endclass

  // Direction the random stimulus pushes the fill level in one block of requests.
  typedef enum logic [1:0] {
    TREND_FILL,
    TREND_DRAIN,
    TREND_CHURN
  } fill_trend_t;

  logic clk;
  logic rst_n;

  ils_req_if req_if ();
  ils_rsp_if rsp_if ();

  list_scoreboard sb;

  // Set by the stimulus process to ask the response side for one long hold-off.
  // The response side counts the stretch itself and clears the flag when done.
  bit hold_request;
  // When set, the request side offers back-to-back transfers with no idle cycles.
  bit req_steady;

  indexed_list_store dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Safety net: a stuck handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Idle lengths: half of them zero, most of the rest a few cycles, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 15);
    else return $urandom_range(20, 60);
  endfunction

  // Transfer monitor. Both channels are sampled at the rising edge, where the
  // values seen are the ones that settled during the previous cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.req_type, req_if.position, req_if.data_in);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.data_out, rsp_if.status, rsp_if.entry_count);
    end
  end

  // Response side: random ready pattern with occasional steady stretches, and
  // one long hold-off on request so the result register fills and the block
  // has to stall its input.
  initial begin : response_side
    int gap;
    int run;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        rsp_if.ready <= 1'b1;
        run = $urandom_range(1, 8);
        repeat (run) @(posedge clk);
      end
    end
  end

  // Offers one request and returns at the edge where it is transferred. Valid
  // stays high so that a following request can go out in the next cycle.
  task automatic send_request(input logic [ils_pkg::REQ_W-1:0] kind,
                              input logic [ils_pkg::POS_W-1:0] pos,
                              input logic [ils_pkg::PORT_DW-1:0] word);
    int gap;
    gap = req_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.position <= pos;
    req_if.data_in  <= word;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
  endtask

  // One random request shaped by the current trend. Positions mostly land inside
  // the list, some from its end up to CAPACITY and some anywhere in 0..255.
  task automatic send_random_request(input fill_trend_t trend);
    int                          r;
    int                          held;
    int                          t_front, t_append, t_remove_at, t_remove_first, t_read;
    logic [ils_pkg::REQ_W-1:0]   kind;
    logic [ils_pkg::POS_W-1:0]   pos;
    logic [ils_pkg::PORT_DW-1:0] word;
    case (trend)
      TREND_FILL: begin
        t_front = 30; t_append = 60; t_remove_at = 70; t_remove_first = 78; t_read = 98;
      end
      TREND_DRAIN: begin
        t_front = 8; t_append = 15; t_remove_at = 45; t_remove_first = 65; t_read = 98;
      end
      default: begin
        t_front = 18; t_append = 36; t_remove_at = 54; t_remove_first = 68; t_read = 98;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < t_front) kind = ils_pkg::REQ_INSERT_FRONT;
    else if (r < t_append) kind = ils_pkg::REQ_APPEND_END;
    else if (r < t_remove_at) kind = ils_pkg::REQ_REMOVE_AT;
    else if (r < t_remove_first) kind = ils_pkg::REQ_REMOVE_FIRST;
    else if (r < t_read) kind = ils_pkg::REQ_READ_AT;
    else kind = ils_pkg::REQ_W'($urandom_range(5, 7));

    held = sb.entries_held();
    r = $urandom_range(0, 99);
    if (held > 0 && r < 80) pos = ils_pkg::POS_W'($urandom_range(0, held - 1));
    else if (r < 92) pos = ils_pkg::POS_W'($urandom_range(held, ils_pkg::CAPACITY));
    else pos = ils_pkg::POS_W'($urandom_range(0, 255));

    r = $urandom_range(0, 99);
    if (r < 5) word = '0;
    else if (r < 10) word = '1;
    else word = $urandom;

    send_request(kind, pos, word);
  endtask

  initial begin : stimulus
    fill_trend_t trend;
    int          waited;
    sb = new();
    hold_request = 1'b0;
    req_steady   = 1'b0;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= ils_pkg::REQ_INSERT_FRONT;
    req_if.position <= '0;
    req_if.data_in  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. On the empty list: read out of range, remove at the top
    // position out of range, and remove first on an empty list.
    send_request(ils_pkg::REQ_READ_AT, 8'd0, 32'h0);
    send_request(ils_pkg::REQ_REMOVE_AT, 8'hFF, 32'hFFFF_FFFF);
    send_request(ils_pkg::REQ_REMOVE_FIRST, 8'd0, 32'h0);
    // Fill to capacity with both insert kinds, data extremes first.
    send_request(ils_pkg::REQ_INSERT_FRONT, 8'd0, 32'hFFFF_FFFF);
    send_request(ils_pkg::REQ_APPEND_END, 8'd0, 32'h0000_0000);
    for (int i = 2; i < ils_pkg::CAPACITY; i++) begin
      if (i % 2 == 0) send_request(ils_pkg::REQ_APPEND_END, 8'd0, 32'hA5A5_0000 | i);
      else send_request(ils_pkg::REQ_INSERT_FRONT, 8'd0, 32'h5A5A_0000 | i);
    end
    // Inserts into a full list must be refused and change nothing.
    send_request(ils_pkg::REQ_INSERT_FRONT, 8'd0, 32'h1234_5678);
    send_request(ils_pkg::REQ_APPEND_END, 8'd0, 32'h8765_4321);
    // Reads at the last entry, at the count itself, and at the top position.
    send_request(ils_pkg::REQ_READ_AT, 8'(ils_pkg::CAPACITY - 1), 32'h0);
    send_request(ils_pkg::REQ_READ_AT, 8'(ils_pkg::CAPACITY), 32'h0);
    send_request(ils_pkg::REQ_READ_AT, 8'hFF, 32'h0);
    // Removes at the back, at the front, and of the first entry.
    send_request(ils_pkg::REQ_REMOVE_AT, 8'(ils_pkg::CAPACITY - 1), 32'h0);
    send_request(ils_pkg::REQ_REMOVE_AT, 8'd0, 32'h0);
    send_request(ils_pkg::REQ_REMOVE_FIRST, 8'd0, 32'h0);
    // Unused request codes are answered with ok and leave the list as it was.
    send_request(ils_pkg::REQ_W'(5), 8'h55, 32'hDEAD_BEEF);
    send_request(ils_pkg::REQ_W'(6), 8'hAA, 32'hFFFF_FFFF);
    send_request(ils_pkg::REQ_W'(7), 8'hFF, 32'h0);

    // Random part, in blocks that each push the fill level one way. Some
    // blocks run with no idle cycles on the request side.
    trend = TREND_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: trend = TREND_FILL;
          1: trend = TREND_DRAIN;
          default: trend = TREND_CHURN;
        endcase
        req_steady = ($urandom_range(0, 3) == 0);
      end
      // Long receiver hold-off while requests keep coming back to back: the
      // pending response blocks the result register and ready must drop.
      if (n == 250) begin
        hold_request = 1'b1;
        req_steady   = 1'b1;
      end
      if (n == 290) req_steady = 1'b0;
      // Pause the request side until every owed response has been transferred.
      if (n == 450) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_random_request(trend);
    end
    req_if.valid <= 1'b0;

    // Wait for the last responses, then a few more cycles so that anything
    // extra the block might emit is still seen by the monitor.
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.pending() != 0)
        $display("%0d responses never arrived", sb.pending());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
